@@ hw/rtl/bbb_pkg.sv @@
package bbb_pkg;

	localparam int SYM_W   = 16;
	localparam int PRICE_W = 24;
	localparam int VOL_W   = 20;
	localparam int LEN_W   = 7;
	localparam int MULT_W  = 11;
	localparam int CFG_W   = 20;
	localparam int CIDX_W  = 2;

	localparam logic [LEN_W-1:0]  LEN_RESET  = 7'd20;
	localparam logic [MULT_W-1:0] MULT_RESET = 11'd512;
	localparam logic [VOL_W-1:0]  TVOL_RESET = 20'd1;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_SYMBOL = 2'd0;
	localparam logic [CIDX_W-1:0] REG_LENGTH = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MULT   = 2'd2;
	localparam logic [CIDX_W-1:0] REG_TVOL   = 2'd3;

	typedef enum logic [1:0] {
		ORD_BUY   = 2'd0,
		ORD_SELL  = 2'd1,
		ORD_SHORT = 2'd2,
		ORD_COVER = 2'd3
	} order_kind_t;

	typedef struct packed {
		order_kind_t              kind;
		logic [PRICE_W-1:0]       price;
		logic [VOL_W-1:0]         volume;
		logic                     last;
	} order_t;

	// Outcome of the band test for one bar.
	typedef struct packed {
		logic done;
		logic hit;
		logic up;
	} verdict_t;

endpackage

@@ hw/rtl/bbb_ram.sv @@
module bbb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/bbb_band.sv @@
module bbb_band #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             start,
	input  logic [$clog2(MAX_WINDOW+1)-1:0]                  n,
	input  logic [bbb_pkg::PRICE_W-1:0]                      price,
	input  logic [bbb_pkg::PRICE_W+$clog2(MAX_WINDOW)-1:0]   sum,
	input  logic [2*bbb_pkg::PRICE_W+$clog2(MAX_WINDOW)-1:0] sq,
	input  logic [bbb_pkg::MULT_W-1:0]                       mult,
	output bbb_pkg::verdict_t                                verdict
);

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int NW    = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = bbb_pkg::PRICE_W + AW;
	localparam int SQ_W  = 2 * bbb_pkg::PRICE_W + AW;
	localparam int NP_W  = bbb_pkg::PRICE_W + NW;
	localparam int NQ_W  = SQ_W + NW;
	localparam int SS_W  = 2 * SUM_W;
	localparam int KK_W  = 2 * bbb_pkg::MULT_W;
	localparam int VL_W  = NQ_W / 2;
	localparam int VH_W  = NQ_W - VL_W;
	localparam int RL_W  = VL_W + KK_W;
	localparam int RH_W  = VH_W + KK_W;
	localparam int DD_W  = 2 * NP_W;
	localparam int LHS_W = DD_W + 16;
	localparam int RHS_W = NQ_W + KK_W + 1;
	localparam int CMP_W = (RHS_W > LHS_W) ? RHS_W : LHS_W;

	logic            v_s1, v_s2, v_s3;
	logic [NP_W-1:0] np_s1;
	logic [NQ_W-1:0] nq_s1;
	logic [SS_W-1:0] ss_s1;
	logic [KK_W-1:0] kk_s1;
	logic            up_s2, zero_s2;
	logic [NP_W-1:0] dmag_s2;
	logic [NQ_W-1:0] var_s2;
	logic            up_s3, zero_s3;
	logic [DD_W-1:0] dd_s3;
	logic [RL_W-1:0] rlo_s3;
	logic [RH_W-1:0] rhi_s3;
	logic [NP_W:0]   dif;
	logic [CMP_W-1:0] lhs, rhs;
	bbb_pkg::verdict_t verdict_q;

	// Signed deviation of N*price from the running sum, one bit wider.
	assign dif = {1'b0, np_s1} - (NP_W + 1)'(sum);
	assign lhs = CMP_W'({dd_s3, 16'b0});
	assign rhs = (CMP_W'(rhi_s3) << VL_W) + CMP_W'(rlo_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			verdict_q <= '0;
		end else begin
			v_s1           <= start;
			v_s2           <= v_s1;
			v_s3           <= v_s2;
			verdict_q.done <= v_s3;
			if (v_s3) begin
				verdict_q.hit <= !zero_s3 && (lhs > rhs);
				verdict_q.up  <= up_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			np_s1 <= NP_W'(n) * NP_W'(price);
			nq_s1 <= NQ_W'(sq) * NQ_W'(n);
			ss_s1 <= SS_W'(sum) * SS_W'(sum);
			kk_s1 <= KK_W'(mult) * KK_W'(mult);
		end
		if (v_s1) begin
			up_s2   <= !dif[NP_W];
			zero_s2 <= (dif == '0);
			dmag_s2 <= dif[NP_W] ? NP_W'(~dif + 1'b1) : dif[NP_W-1:0];
			// N*Q - S*S is never negative, so it fits the width of N*Q.
			var_s2  <= nq_s1 - NQ_W'(ss_s1);
		end
		if (v_s2) begin
			up_s3   <= up_s2;
			zero_s3 <= zero_s2;
			dd_s3   <= DD_W'(dmag_s2) * DD_W'(dmag_s2);
			rlo_s3  <= RL_W'(var_s2[VL_W-1:0]) * RL_W'(kk_s1);
			rhi_s3  <= RH_W'(var_s2[NQ_W-1:VL_W]) * RH_W'(kk_s1);
		end
	end

	assign verdict = verdict_q;

endmodule

@@ hw/rtl/bbb_outq.sv @@
module bbb_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            push_two,
	input  bbb_pkg::order_t push_e0,
	input  bbb_pkg::order_t push_e1,
	output logic            push_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output bbb_pkg::order_t head
);

	logic [1:0]      cnt_q;
	bbb_pkg::order_t ent0_q, ent1_q;
	logic            pop;

	assign pop        = out_valid && out_ready;
	assign push_ready = (cnt_q == 2'd0);
	assign out_valid  = (cnt_q != 2'd0);
	assign head       = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push) begin
			cnt_q <= push_two ? 2'd2 : 2'd1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent0_q <= push_e0;
			ent1_q <= push_e1;
		end else if (pop) begin
			ent0_q <= ent1_q;
		end
	end

endmodule

@@ hw/rtl/bollinger_band_breakout_signal.sv @@
// Flow: a watched bar that breaks out passes the read, update and start states, waits for
// the band verdict in the wait state and pushes its order beats from the emit state; bars
// on other symbols are dropped in the accept cycle. Back-pressure: a watched bar holds
// in_ready low through the price ring read-modify-write and, once the window is full, the
// four-stage band test; a bar that emits orders also waits until the two-beat order queue
// has drained. Reset is asynchronous and active low; it clears the sums, fill count and
// write slot and loads the register defaults. Ring contents are not cleared.
module bollinger_band_breakout_signal #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bbb_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [bbb_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bbb_pkg::SYM_W-1:0]   symbol_id,
	input  logic [bbb_pkg::PRICE_W-1:0] bar_price,
	input  logic [bbb_pkg::VOL_W-1:0]   long_volume,
	input  logic [bbb_pkg::VOL_W-1:0]   short_volume,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  order_kind,
	output logic [bbb_pkg::PRICE_W-1:0] order_price,
	output logic [bbb_pkg::VOL_W-1:0]   order_volume,
	output logic                        last_order
);

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int NW    = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = bbb_pkg::PRICE_W + AW;
	localparam int SQ_W  = 2 * bbb_pkg::PRICE_W + AW;
	localparam int PSQ_W = 2 * bbb_pkg::PRICE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPD,
		ST_START,
		ST_WAIT,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [bbb_pkg::SYM_W-1:0]  sym_q;
	logic [bbb_pkg::LEN_W-1:0]  len_q;
	logic [bbb_pkg::MULT_W-1:0] mult_q;
	logic [bbb_pkg::VOL_W-1:0]  tvol_q;

	logic [AW-1:0]    ws_q;
	logic [NW-1:0]    fill_q;
	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  sq_q;
	logic             up_q;

	logic [bbb_pkg::PRICE_W-1:0] price_q;
	logic [bbb_pkg::VOL_W-1:0]   long_q;
	logic [bbb_pkg::VOL_W-1:0]   short_q;
	logic [AW-1:0]               slot_q;
	logic [bbb_pkg::PRICE_W-1:0] old_q;
	logic [PSQ_W-1:0]            oldsq_q;
	logic [PSQ_W-1:0]            psq_q;

	logic [31:0]                 len_ext;
	logic [NW-1:0]               n_eff;
	logic [AW-1:0]               slot_c;
	logic [NW-1:0]               slot_inc;
	logic [AW-1:0]               slot_next;
	logic                        accept;
	logic                        take;
	logic                        full_before;
	logic                        full_after;
	logic [bbb_pkg::PRICE_W-1:0] ram_rdata;
	logic                        ram_we;

	bbb_pkg::verdict_t verdict;
	logic              band_start;

	logic            has_close, has_open, push, push_ready;
	bbb_pkg::order_t e_close, e_open, push_e0, push_e1, head;

	// The window length clamps to 1..MAX_WINDOW.
	assign len_ext = 32'(len_q);
	always_comb begin
		if (len_q == '0) begin
			n_eff = NW'(1);
		end else if (len_ext > 32'(MAX_WINDOW)) begin
			n_eff = NW'(MAX_WINDOW);
		end else begin
			n_eff = NW'(len_ext);
		end
	end

	assign slot_c    = (NW'(ws_q) >= n_eff) ? '0 : ws_q;
	assign slot_inc  = NW'(slot_q) + NW'(1);
	assign slot_next = (slot_inc >= n_eff) ? '0 : slot_inc[AW-1:0];

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign take        = accept && (symbol_id == sym_q);
	assign full_before = (fill_q >= n_eff);
	assign full_after  = full_before || ((fill_q + NW'(1)) == n_eff);
	assign ram_we      = (state_q == ST_UPD);
	assign band_start  = (state_q == ST_START);

	bbb_ram #(
		.WIDTH (bbb_pkg::PRICE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (price_q),
		.re    (take),
		.raddr (slot_c),
		.rdata (ram_rdata)
	);

	bbb_band #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_band (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (band_start),
		.n       (n_eff),
		.price   (price_q),
		.sum     (sum_q),
		.sq      (sq_q),
		.mult    (mult_q),
		.verdict (verdict)
	);

	// An upper breakout closes any shorts, then opens a long if none is held; a lower one mirrors it.
	always_comb begin
		has_close      = up_q ? (short_q != '0) : (long_q != '0);
		has_open       = up_q ? (long_q == '0) : (short_q == '0);
		e_close.kind   = up_q ? bbb_pkg::ORD_COVER : bbb_pkg::ORD_SELL;
		e_close.price  = price_q;
		e_close.volume = up_q ? short_q : long_q;
		e_close.last   = !has_open;
		e_open.kind    = up_q ? bbb_pkg::ORD_BUY : bbb_pkg::ORD_SHORT;
		e_open.price   = price_q;
		e_open.volume  = tvol_q;
		e_open.last    = 1'b1;
		push_e0        = has_close ? e_close : e_open;
		push_e1        = e_open;
	end

	assign push = (state_q == ST_EMIT) && push_ready && (has_close || has_open);

	bbb_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_two   (has_close && has_open),
		.push_e0    (push_e0),
		.push_e1    (push_e1),
		.push_ready (push_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.head       (head)
	);

	assign order_kind   = head.kind;
	assign order_price  = head.price;
	assign order_volume = head.volume;
	assign last_order   = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sym_q   <= '0;
			len_q   <= bbb_pkg::LEN_RESET;
			mult_q  <= bbb_pkg::MULT_RESET;
			tvol_q  <= bbb_pkg::TVOL_RESET;
			ws_q    <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
			up_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					bbb_pkg::REG_SYMBOL: begin
						sym_q <= cfg_data[bbb_pkg::SYM_W-1:0];
					end
					bbb_pkg::REG_LENGTH: begin
						len_q  <= cfg_data[bbb_pkg::LEN_W-1:0];
						ws_q   <= '0;
						fill_q <= '0;
						sum_q  <= '0;
						sq_q   <= '0;
					end
					bbb_pkg::REG_MULT: begin
						mult_q <= cfg_data[bbb_pkg::MULT_W-1:0];
					end
					bbb_pkg::REG_TVOL: begin
						tvol_q <= cfg_data[bbb_pkg::VOL_W-1:0];
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					ws_q <= slot_next;
					if (full_before) begin
						sum_q <= sum_q - SUM_W'(old_q) + SUM_W'(price_q);
						sq_q  <= sq_q - SQ_W'(oldsq_q) + SQ_W'(psq_q);
					end else begin
						fill_q <= fill_q + NW'(1);
						sum_q  <= sum_q + SUM_W'(price_q);
						sq_q   <= sq_q + SQ_W'(psq_q);
					end
					state_q <= full_after ? ST_START : ST_IDLE;
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (verdict.done) begin
						up_q    <= verdict.up;
						state_q <= verdict.hit ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			price_q <= bar_price;
			long_q  <= long_volume;
			short_q <= short_volume;
			slot_q  <= slot_c;
		end
		if (state_q == ST_READ) begin
			old_q   <= ram_rdata;
			oldsq_q <= PSQ_W'(ram_rdata) * PSQ_W'(ram_rdata);
			psq_q   <= PSQ_W'(price_q) * PSQ_W'(price_q);
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (NW'(ws_q) < n_eff))
		else $error("write slot outside the window");

	assert property (@(posedge clk) disable iff (!arst_n)
		take |=> ##1 ram_we)
		else $error("ring write missing two cycles after a watched bar");

	assert property (@(posedge clk) disable iff (!arst_n)
		verdict.done |-> (state_q == ST_WAIT))
		else $error("band verdict arrived outside the wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !out_valid)
		else $error("order beats pushed over a pending beat");
`endif

endmodule

@@ tb/bollinger_band_breakout_signal_tb.sv @@
module bollinger_band_breakout_signal_tb;
	import bbb_pkg::*;

	localparam int MAX_WIN      = 64;
	localparam int RAND_BARS    = 1800;
	localparam int DRAIN_PAD    = 24;
	localparam int QUIET_LIMIT  = 5000;
	localparam int DUE_DEPTH    = 16;
	localparam int MAX_ROWS     = 64;

	typedef struct packed {
		logic [SYM_W-1:0]   sym;
		logic [PRICE_W-1:0] px;
		logic [VOL_W-1:0]   lv;
		logic [VOL_W-1:0]   sv;
	} bar_t;

	// One line of the directed script: either a register write or a bar.
	// typed_n >= 0 means the orders are spelled out here instead of predicted.
	typedef struct {
		bit                is_cfg;
		logic [CIDX_W-1:0] idx;
		logic [CFG_W-1:0]  val;
		bar_t              b;
		int                typed_n;
		order_t            o0;
		order_t            o1;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [SYM_W-1:0]    symbol_id = '0;
	logic [PRICE_W-1:0]  bar_price = '0;
	logic [VOL_W-1:0]    long_volume = '0;
	logic [VOL_W-1:0]    short_volume = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [1:0]          order_kind;
	logic [PRICE_W-1:0]  order_price;
	logic [VOL_W-1:0]    order_volume;
	logic                last_order;

	bollinger_band_breakout_signal #(.MAX_WINDOW(MAX_WIN)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.symbol_id    (symbol_id),
		.bar_price    (bar_price),
		.long_volume  (long_volume),
		.short_volume (short_volume),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.order_kind   (order_kind),
		.order_price  (order_price),
		.order_volume (order_volume),
		.last_order   (last_order)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies and window state of the band predictor.
	logic [SYM_W-1:0]   watch_sym = '0;
	logic [LEN_W-1:0]   win_len = LEN_RESET;
	logic [MULT_W-1:0]  band_k = MULT_RESET;
	logic [VOL_W-1:0]   open_vol = TVOL_RESET;
	logic [PRICE_W-1:0] ring_px [MAX_WIN];
	int                 slot_ptr = 0;
	int                 filled = 0;
	logic [63:0]        px_sum = '0;
	logic [63:0]        px_sq_sum = '0;

	// Expected orders wait in a small ring; due_wr - due_rd is the number outstanding.
	order_t due_buf [DUE_DEPTH];
	int     due_wr = 0;
	int     due_rd = 0;
	row_t   bench_rows [MAX_ROWS];
	int     row_cnt = 0;
	order_t exp_ord;
	int     mismatches = 0;
	int     quiet_cycles = 0;
	bit     calm = 1'b0;
	int     hold_left = 0;
	int     rdy_roll;

	function automatic void expect_order(input order_t o);
		due_buf[due_wr % DUE_DEPTH] = o;
		due_wr++;
	endfunction

	function automatic void add_row(input row_t r);
		bench_rows[row_cnt] = r;
		row_cnt++;
	endfunction

	function automatic order_t mk_order(input order_kind_t kind, input logic [PRICE_W-1:0] px,
			input logic [VOL_W-1:0] vol, input logic last);
		order_t o;
		o.kind = kind;
		o.price = px;
		o.volume = vol;
		o.last = last;
		return o;
	endfunction

	function automatic row_t cfg_row(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		r.typed_n = -1;
		return r;
	endfunction

	function automatic row_t bar_row(input logic [SYM_W-1:0] sym, input logic [PRICE_W-1:0] px,
			input logic [VOL_W-1:0] lv, input logic [VOL_W-1:0] sv, input int typed_n = -1,
			input order_t o0 = '0, input order_t o1 = '0);
		row_t r;
		r = '{default: '0};
		r.b.sym = sym;
		r.b.px = px;
		r.b.lv = lv;
		r.b.sv = sv;
		r.typed_n = typed_n;
		r.o0 = o0;
		r.o1 = o1;
		return r;
	endfunction

	// Advances the price window by one bar and works out the orders it triggers.
	function automatic void predict_bar(input bar_t b, output int cnt, output order_t o [2]);
		int          n;
		int          slot;
		logic [63:0] old;
		logic [63:0] np;
		logic [63:0] dmag;
		logic [127:0] v;
		logic [127:0] lhs;
		logic [127:0] rhs;
		bit          up;
		cnt = 0;
		o[0] = '0;
		o[1] = '0;
		if (b.sym != watch_sym)
			return;
		n = (win_len == 0) ? 1 : (win_len > MAX_WIN) ? MAX_WIN : int'(win_len);
		slot = slot_ptr;
		if (slot >= n)
			slot = 0;
		if (filled >= n) begin
			old = 64'(ring_px[slot]);
			px_sum -= old;
			px_sq_sum -= old * old;
		end else begin
			filled++;
		end
		ring_px[slot] = b.px;
		px_sum += 64'(b.px);
		px_sq_sum += 64'(b.px) * 64'(b.px);
		slot++;
		slot_ptr = (slot >= n) ? 0 : slot;
		if (filled < n)
			return;
		np = 64'(n) * 64'(b.px);
		if (np == px_sum)
			return;
		up = np > px_sum;
		dmag = up ? np - px_sum : px_sum - np;
		v = 128'(n) * 128'(px_sq_sum) - 128'(px_sum) * 128'(px_sum);
		rhs = v * 128'(band_k) * 128'(band_k);
		lhs = (128'(dmag) * 128'(dmag)) << 16;
		if (lhs <= rhs)
			return;
		if (up) begin
			if (b.sv != 0) begin
				o[cnt] = mk_order(ORD_COVER, b.px, b.sv, 1'b0);
				cnt++;
			end
			if (b.lv == 0) begin
				o[cnt] = mk_order(ORD_BUY, b.px, open_vol, 1'b0);
				cnt++;
			end
		end else begin
			if (b.lv != 0) begin
				o[cnt] = mk_order(ORD_SELL, b.px, b.lv, 1'b0);
				cnt++;
			end
			if (b.sv == 0) begin
				o[cnt] = mk_order(ORD_SHORT, b.px, open_vol, 1'b0);
				cnt++;
			end
		end
		if (cnt > 0)
			o[cnt-1].last = 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	function automatic logic [VOL_W-1:0] rand_vol();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return '0;
		if (r < 55)
			return '1;
		return VOL_W'($urandom_range(1, 20'hFFFFF));
	endfunction

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_SYMBOL: watch_sym = val[SYM_W-1:0];
			REG_LENGTH: begin
				// A new window length restarts the history.
				win_len = val[LEN_W-1:0];
				slot_ptr = 0;
				filled = 0;
				px_sum = '0;
				px_sq_sum = '0;
			end
			REG_MULT:   band_k = val[MULT_W-1:0];
			REG_TVOL:   open_vol = val[VOL_W-1:0];
			default: ;
		endcase
	endtask

	// Holds the sender until every expected order has come out and the block is quiet.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_wr != due_rd)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic send_bar(input bar_t b, input int gap, output int cnt, output order_t o [2]);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		symbol_id <= b.sym;
		bar_price <= b.px;
		long_volume <= b.lv;
		short_volume <= b.sv;
		do
			@(posedge clk);
		while (!in_ready);
		predict_bar(b, cnt, o);
	endtask

	task automatic check_field(input string what, input logic [PRICE_W-1:0] want,
			input logic [PRICE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Receiver: ready toggles in runs, mostly short, now and then a long stall; in calm phases it stays high.
	always @(negedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else begin
			rdy_roll = $urandom_range(0, 99);
			if (rdy_roll < 60) begin
				out_ready <= 1'b1;
				hold_left <= $urandom_range(0, 3);
			end else if (rdy_roll < 95) begin
				out_ready <= 1'b0;
				hold_left <= $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b0;
				hold_left <= $urandom_range(20, 60);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (due_wr == due_rd) begin
				$display("%0t: order beat with none expected, expected none, actual %0d %h %h %b",
					$time, order_kind, order_price, order_volume, last_order);
				mismatches++;
			end else begin
				exp_ord = due_buf[due_rd % DUE_DEPTH];
				due_rd++;
				check_field("order_kind", PRICE_W'(exp_ord.kind), PRICE_W'(order_kind));
				check_field("order_price", exp_ord.price, order_price);
				check_field("order_volume", PRICE_W'(exp_ord.volume), PRICE_W'(order_volume));
				check_field("last_order", PRICE_W'(exp_ord.last), PRICE_W'(last_order));
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("[bollinger_band_breakout_signal] ERROR");
		$finish;
	end

	initial begin
		bar_t   b;
		order_t o [2];
		int     cnt;
		int     bars_sent;
		int     nbars;
		int     n_eff;
		int     roll;
		int     amp;
		int     mag;
		int     ofs;
		longint center;
		longint p;
		bit     first_phase;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Window of two with a zero multiplier makes every move a breakout.
		add_row(cfg_row(REG_LENGTH, 20'd2));
		add_row(cfg_row(REG_MULT, 20'd0));
		add_row(cfg_row(REG_TVOL, 20'hFFFFF));
		add_row(bar_row(16'd0, 24'd100, 20'd0, 20'd0, 0));
		add_row(bar_row(16'd1, 24'd5, 20'd0, 20'd0, 0));
		add_row(bar_row(16'd0, 24'd200, 20'd0, 20'd7, 2,
			mk_order(ORD_COVER, 24'd200, 20'd7, 1'b0),
			mk_order(ORD_BUY, 24'd200, 20'hFFFFF, 1'b1)));
		add_row(bar_row(16'd0, 24'd200, 20'd5, 20'd0, 0));
		add_row(bar_row(16'd0, 24'd0, 20'hFFFFF, 20'd0, 2,
			mk_order(ORD_SELL, 24'd0, 20'hFFFFF, 1'b0),
			mk_order(ORD_SHORT, 24'd0, 20'hFFFFF, 1'b1)));
		add_row(bar_row(16'd0, 24'hFFFFFF, 20'd3, 20'hFFFFF, 1,
			mk_order(ORD_COVER, 24'hFFFFFF, 20'hFFFFF, 1'b1)));
		add_row(bar_row(16'd0, 24'hFFFFFF, 20'd0, 20'd0, 0));
		// With two prices the band test reduces to 256 > k.
		add_row(cfg_row(REG_MULT, 20'd2047));
		add_row(bar_row(16'd0, 24'd0, 20'd0, 20'd0, 0));
		add_row(cfg_row(REG_MULT, 20'd255));
		add_row(bar_row(16'd0, 24'd1, 20'd0, 20'd0, 1,
			mk_order(ORD_BUY, 24'd1, 20'hFFFFF, 1'b1)));
		add_row(cfg_row(REG_MULT, 20'd256));
		add_row(bar_row(16'd0, 24'd9, 20'd0, 20'd0, 0));
		add_row(cfg_row(REG_TVOL, 20'd0));
		add_row(cfg_row(REG_MULT, 20'd0));
		add_row(bar_row(16'd0, 24'd2, 20'd0, 20'd0, 1,
			mk_order(ORD_SHORT, 24'd2, 20'd0, 1'b1)));
		// A length of zero behaves as one, and a single price never leaves its mean.
		add_row(cfg_row(REG_LENGTH, 20'd0));
		add_row(bar_row(16'd0, 24'd50, 20'd0, 20'd0, 0));
		add_row(bar_row(16'd0, 24'd60, 20'd7, 20'd7, 0));
		add_row(cfg_row(REG_SYMBOL, 20'hFFFFF));
		add_row(cfg_row(REG_LENGTH, 20'hABC83));
		add_row(cfg_row(REG_TVOL, 20'd12345));
		add_row(cfg_row(REG_MULT, 20'h7FA00));
		add_row(bar_row(16'hFFFF, 24'd10, 20'd0, 20'd0));
		add_row(bar_row(16'd0, 24'd999, 20'd0, 20'd0, 0));
		add_row(bar_row(16'hFFFF, 24'd10, 20'd0, 20'd0));
		add_row(bar_row(16'hFFFF, 24'd10, 20'd0, 20'd0));
		add_row(bar_row(16'hFFFF, 24'd40, 20'd0, 20'd0));
		add_row(bar_row(16'hFFFF, 24'd11, 20'hFFFFF, 20'hFFFFF));
		add_row(bar_row(16'hFFFF, 24'd0, 20'd1, 20'd0));
		add_row(bar_row(16'hFFFF, 24'd900, 20'd0, 20'd4));

		for (int i = 0; i < row_cnt; i++) begin
			if (bench_rows[i].is_cfg) begin
				settle();
				write_reg(bench_rows[i].idx, bench_rows[i].val);
			end else begin
				send_bar(bench_rows[i].b, pick_gap(), cnt, o);
				if (bench_rows[i].typed_n >= 1)
					expect_order(bench_rows[i].o0);
				if (bench_rows[i].typed_n >= 2)
					expect_order(bench_rows[i].o1);
				if (bench_rows[i].typed_n < 0)
					for (int j = 0; j < cnt; j++)
						expect_order(o[j]);
			end
		end

		bars_sent = 0;
		first_phase = 1'b1;
		while (bars_sent < RAND_BARS) begin
			settle();
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 4)
				write_reg(REG_SYMBOL, CFG_W'($urandom()));
			if ($urandom_range(0, 9) < 7) begin
				roll = $urandom_range(0, 99);
				if (roll < 60)
					n_eff = $urandom_range(2, 6);
				else if (roll < 80)
					n_eff = $urandom_range(7, 20);
				else if (roll < 88)
					n_eff = MAX_WIN;
				else if (roll < 92)
					n_eff = $urandom_range(0, 1);
				else if (roll < 96)
					n_eff = $urandom_range(65, 127);
				else
					n_eff = $urandom_range(21, 63);
				// Upper bits beyond the register are don't-care.
				write_reg(REG_LENGTH, {13'($urandom()), 7'(n_eff)});
			end
			if ($urandom_range(0, 9) < 6) begin
				roll = $urandom_range(0, 99);
				if (roll < 30)
					mag = $urandom_range(128, 640);
				else if (roll < 45)
					mag = 0;
				else if (roll < 55)
					mag = 2047;
				else if (roll < 65)
					mag = $urandom_range(1, 127);
				else
					mag = $urandom_range(256, 1200);
				write_reg(REG_MULT, {9'($urandom()), 11'(mag)});
			end
			if ($urandom_range(0, 9) < 5) begin
				roll = $urandom_range(0, 99);
				write_reg(REG_TVOL, (roll < 15) ? 20'd0 : (roll < 30) ? 20'hFFFFF :
					CFG_W'($urandom_range(1, 20'hFFFFF)));
			end

			n_eff = (win_len == 0) ? 1 : (win_len > MAX_WIN) ? MAX_WIN : int'(win_len);
			nbars = n_eff + $urandom_range(30, 120);
			roll = $urandom_range(0, 99);
			if (roll < 10)
				center = $urandom_range(0, 1000);
			else if (roll < 20)
				center = 24'hFFFFFF - $urandom_range(0, 1000);
			else
				center = $urandom_range(0, 24'hFFFFFF);
			amp = 1 << $urandom_range(0, 16);

			for (int i = 0; i < nbars && bars_sent < RAND_BARS; i++) begin
				// Prices wander around a center, with spikes that push through the bands.
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					mag = $urandom_range(4, 30);
					p = center + ($urandom_range(0, 1) ? 1 : -1) * longint'(amp) * mag;
				end else if (roll < 12) begin
					p = $urandom_range(0, 24'hFFFFFF);
				end else begin
					ofs = $urandom_range(0, 2 * amp);
					p = center + ofs - amp;
				end
				if (p < 0)
					p = 0;
				if (p > 24'hFFFFFF)
					p = 24'hFFFFFF;
				if (roll >= 12 && roll < 15)
					center = p;
				b.px = PRICE_W'(p);
				b.sym = ($urandom_range(0, 99) < 85) ? watch_sym : SYM_W'($urandom());
				b.lv = rand_vol();
				b.sv = rand_vol();
				if ((first_phase && i == 10) || $urandom_range(0, 199) == 0)
					settle();
				send_bar(b, pick_gap(), cnt, o);
				for (int j = 0; j < cnt; j++)
					expect_order(o[j]);
				bars_sent++;
			end
			first_phase = 1'b0;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		calm = 1'b0;
		while (due_wr != due_rd)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("[bollinger_band_breakout_signal] OK");
		else
			$display("[bollinger_band_breakout_signal] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/bbb_pkg.sv
hw/rtl/bbb_ram.sv
hw/rtl/bbb_band.sv
hw/rtl/bbb_outq.sv
hw/rtl/bollinger_band_breakout_signal.sv
tb/bollinger_band_breakout_signal_tb.sv
